// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion, disabled while reset is high.
`define STT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define STT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define STT_ASSERT(label, clk, rst, prop, msg)
`define STT_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the sorted time-slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

  localparam int ENTRIES_DEF   = 32;
  localparam int NAME_BITS_DEF = 64;

  localparam int KEY_W    = 8;
  localparam int TAG_W    = 64;
  localparam int S_DATA_W = 80;   // 73 field bits padded to whole bytes
  localparam int M_DATA_W = 16;   // 13 field bits padded to whole bytes
  localparam int OCC_W    = 6;
  localparam int SLOT_W   = 5;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_TAKEN   = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } req_kind_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_UPD  = 1'b1
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch request, register compare flags
    logic commit;   // apply update, load result word
  } cmd_t;

endpackage

// ===== hdl/stt_ctrl.sv =====
// ----------------------------------------------------------------------------
// stt_ctrl
// Two-state sequencer: capture a request, then commit it into the result reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::cmd_t cmd
);

  stt_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stt_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    in_ready    = 1'b0;
    unique case (state)
      stt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stt_pkg::S_UPD;
        end
      end
      stt_pkg::S_UPD: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = stt_pkg::S_IDLE;
        end
      end
      default: state_next = stt_pkg::S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== hdl/stt_datapath.sv =====
// ----------------------------------------------------------------------------
// stt_datapath
// Row of ordered key/tag cells with per-cell compare and shift logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stt_datapath #(
  parameter int ENTRIES   = stt_pkg::ENTRIES_DEF,
  parameter int NAME_BITS = stt_pkg::NAME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stt_pkg::cmd_t                 cmd,
  input  logic                          in_action,
  input  logic [stt_pkg::KEY_W-1:0]     in_key,
  input  logic [stt_pkg::TAG_W-1:0]     in_tag,
  output stt_pkg::status_t              res_status,
  output logic [stt_pkg::OCC_W-1:0]     res_occupancy,
  output logic [stt_pkg::SLOT_W-1:0]    res_slot
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [stt_pkg::KEY_W-1:0] keys [ENTRIES];
  logic [NAME_BITS-1:0]      tags [ENTRIES];
  logic [CNT_W-1:0]          count, count_next;

  logic                      req_action;
  logic [stt_pkg::KEY_W-1:0] req_key;
  logic [NAME_BITS-1:0]      req_tag;

  logic [ENTRIES-1:0] lt_c, eq_c, nm_c;   // below key, key match, key+name match
  logic [ENTRIES-1:0] lt_q, eq_q, nm_q;
  logic [ENTRIES-1:0] bnd;                // one-hot ordered position
  logic [IDX_W-1:0]   pos;
  logic               hit, del_ok, full, do_ins, do_del;
  stt_pkg::status_t   status_c;
  logic [IDX_W-1:0]   slot_c;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lt_c[i] = (CNT_W'(i) < count) && (keys[i] < in_key);
      eq_c[i] = (CNT_W'(i) < count) && (keys[i] == in_key);
      nm_c[i] = eq_c[i] && (tags[i] == in_tag[NAME_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action <= in_action;
      req_key    <= in_key;
      req_tag    <= in_tag[NAME_BITS-1:0];
      lt_q       <= lt_c;
      eq_q       <= eq_c;
      nm_q       <= nm_c;
    end
  end

  // keys are sorted, so lt_q is a thermometer; its edge is the position
  always_comb begin
    pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      bnd[i] = !lt_q[i] && ((i == 0) || lt_q[(i == 0) ? 0 : i - 1]);
      if (bnd[i]) pos = pos | IDX_W'(i);
    end
  end

  assign hit    = |eq_q;
  assign del_ok = |nm_q;
  assign full   = (count == CNT_W'(ENTRIES));

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    slot_c     = '0;
    count_next = count;
    if (req_action == stt_pkg::ACT_INSERT) begin
      if (hit) begin
        status_c = stt_pkg::ST_TAKEN;
        slot_c   = pos;
      end else if (full) begin
        status_c = stt_pkg::ST_FULL;
      end else begin
        status_c   = stt_pkg::ST_DONE;
        slot_c     = pos;
        do_ins     = 1'b1;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (del_ok) begin
        status_c   = stt_pkg::ST_DONE;
        slot_c     = pos;
        do_del     = 1'b1;
        count_next = count - CNT_W'(1);
      end else begin
        status_c = stt_pkg::ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status    <= status_c;
      res_occupancy <= stt_pkg::OCC_W'(count_next);
      res_slot      <= stt_pkg::SLOT_W'(slot_c);
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_ent
    localparam int PRV = (g == 0) ? 0 : g - 1;
    localparam int NXT = (g == ENTRIES - 1) ? g : g + 1;

    always_ff @(posedge clk) begin
      if (cmd.commit && do_ins) begin
        if (bnd[g]) begin
          keys[g] <= req_key;
          tags[g] <= req_tag;
        end else if (g != 0 && !lt_q[g]) begin
          keys[g] <= keys[PRV];
          tags[g] <= tags[PRV];
        end
      end else if (cmd.commit && do_del) begin
        if (g != ENTRIES - 1 && !lt_q[g]) begin
          keys[g] <= keys[NXT];
          tags[g] <= tags[NXT];
        end
      end
    end
  end

endmodule

// ===== hdl/sorted_time_slot_table.sv =====
// ----------------------------------------------------------------------------
// sorted_time_slot_table
// Ordered table of (day, hour) time slots with name tags; insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ group, one word each: insert or delete of a
//   (day, hour) key with a name tag. Each request gives exactly one result
//   word on the m_ group: status, occupancy after the request, and slot.
//   The table stays sorted by key = day*32 + hour; an insert of a key
//   already held reports slot taken, an insert into a full table reports
//   table full, a delete needs both key and name to match.
// Sequence:
//   The accept cycle registers the per-entry compare flags of the whole
//   row; the update state then shifts the row by one place on a done
//   insert or delete and loads the result register. s_tready is low in
//   the update state, so a new request is taken only once the current
//   one has been committed.
// Reset:
//   rst empties the table (entry count zero) and drops m_tvalid.
// Stall:
//   The result register holds while m_tready is low; the next request is
//   still accepted and waits in the update state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_time_slot_table #(
  parameter int ENTRIES   = stt_pkg::ENTRIES_DEF,
  parameter int NAME_BITS = stt_pkg::NAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] action, [3:1] day, [8:4] hour, [72:9] name_tag, [79:73] zero
  input  logic [stt_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status, [7:2] occupancy, [12:8] slot, [15:13] zero
  output logic [stt_pkg::M_DATA_W-1:0]    m_tdata
);

  stt_pkg::cmd_t                  cmd;
  stt_pkg::status_t               res_status;
  logic [stt_pkg::OCC_W-1:0]      res_occupancy;
  logic [stt_pkg::SLOT_W-1:0]     res_slot;
  logic [stt_pkg::KEY_W-1:0]      in_key;

  // key: day in the upper three bits, hour in the lower five
  assign in_key = {s_tdata[3:1], s_tdata[8:4]};

  stt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  stt_datapath #(
    .ENTRIES   (ENTRIES),
    .NAME_BITS (NAME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_action     (s_tdata[0]),
    .in_key        (in_key),
    .in_tag        (s_tdata[72:9]),
    .res_status    (res_status),
    .res_occupancy (res_occupancy),
    .res_slot      (res_slot)
  );

  assign m_tdata = {3'b000, res_slot, res_occupancy, res_status};

  // capture and commit never coincide
  `STT_ASSERT_ALWAYS(a_cmd_excl, clk, !(cmd.capture && cmd.commit), "capture and commit overlap")

  // an accepted word blocks the input during the update state
  `STT_ASSERT(a_one_in_flight, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second word taken too early")

  // with the result register free at accept, the update state commits without waiting
  `STT_ASSERT(a_latency, clk, rst, (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid, "result late")

  // a full report only comes from a full table
  `STT_ASSERT(a_full_occ, clk, rst, (m_tvalid && res_status == stt_pkg::ST_FULL) |-> (res_occupancy == stt_pkg::OCC_W'(ENTRIES)), "full with free entries")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted time-slot table.
// A shadow table predicts status, occupancy and slot for every accepted
// request; result words are matched in order. Directed requests cover the
// corner cases. Random phases then fill, drain and mix the table, with
// random back-pressure and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import stt_pkg::*;

  localparam int TBL_DEPTH   = ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 400000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  typedef struct packed {
    status_t           status;
    logic [OCC_W-1:0]  occ;
    logic [SLOT_W-1:0] slot;
  } slot_result_t;

  // Shadow of the table plus the queue of results still owed by the block.
  class slot_table_board;
    logic [KEY_W-1:0] keys [TBL_DEPTH];
    logic [TAG_W-1:0] tags [TBL_DEPTH];
    int unsigned      held;
    slot_result_t     owed [$];
    int unsigned      errors;
    int unsigned      seen [4];
    int unsigned      peak_occ;

    function new();
      held = 0;
      errors = 0;
      peak_occ = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    // Decode an accepted request word and queue its expected result.
    function void note_request(logic [S_DATA_W-1:0] w);
      req_kind_t        act;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      int unsigned      pos;
      bit               hit;
      slot_result_t     r;
      act = req_kind_t'(w[0]);
      key = {w[3:1], w[8:4]};
      tag = w[72:9];
      pos = 0;
      while (pos < held && keys[pos] < key) pos++;
      hit = (pos < held) && (keys[pos] == key);
      r.slot = '0;
      if (act == ACT_INSERT) begin
        if (hit) begin
          r.status = ST_TAKEN;
          r.slot = pos[SLOT_W-1:0];
        end else if (held >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held; i > pos; i--) begin
            keys[i] = keys[i-1];
            tags[i] = tags[i-1];
          end
          keys[pos] = key;
          tags[pos] = tag;
          held++;
          r.status = ST_DONE;
          r.slot = pos[SLOT_W-1:0];
        end
      end else begin
        if (hit && tags[pos] == tag) begin
          for (int i = pos; i + 1 < held; i++) begin
            keys[i] = keys[i+1];
            tags[i] = tags[i+1];
          end
          held--;
          r.status = ST_DONE;
          r.slot = pos[SLOT_W-1:0];
        end else begin
          r.status = ST_MISSING;
        end
      end
      r.occ = held[OCC_W-1:0];
      if (held > peak_occ) peak_occ = held;
      owed.push_back(r);
    endfunction

    // Compare one result word with the oldest owed result.
    function void check_result(logic [M_DATA_W-1:0] w);
      slot_result_t exp_r;
      status_t      got_st;
      got_st = status_t'(w[1:0]);
      if (owed.size() == 0) begin
        $error("result word 0x%h with no request pending", w);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      seen[exp_r.status]++;
      if (got_st != exp_r.status) begin
        $error("status: expected %s, got %s", exp_r.status.name(), got_st.name());
        errors++;
      end
      if (w[7:2] != exp_r.occ) begin
        $error("occupancy: expected %0d, got %0d", exp_r.occ, w[7:2]);
        errors++;
      end
      if (w[12:8] != exp_r.slot) begin
        $error("slot: expected %0d, got %0d", exp_r.slot, w[12:8]);
        errors++;
      end
    endfunction

    // Random entry currently held, for well-formed deletes and duplicates.
    function bit pick_entry(output logic [KEY_W-1:0] key, output logic [TAG_W-1:0] tag);
      int unsigned idx;
      if (held == 0) return 0;
      idx = $urandom_range(held - 1);
      key = keys[idx];
      tag = tags[idx];
      return 1;
    endfunction
  endclass

  slot_table_board board = new();

  // Shared pacing controls.
  bit          quiet    = 1'b0;  // no idling on either side
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned n_sent   = 0;
  int unsigned cycle_count = 0;

  sorted_time_slot_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** sorted_time_slot_table: FAILED **");
      $finish;
    end
  end

  // Monitors: requests and results taken at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_request(s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
    end
  end

  // Mostly short, occasionally long idle stretch.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(4, 1);
    return $urandom_range(30, 10);
  endfunction

  // Receiver back-pressure, updated at the falling edge.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(99) < 25) begin
      m_tready = 1'b0;
      stall_left = idle_len();
    end else begin
      m_tready = 1'b1;
    end
  end

  // Offer one request word, hold it until accepted, then idle a while.
  task automatic send_request(req_kind_t act, logic [2:0] day, logic [4:0] hour,
                              logic [TAG_W-1:0] tag);
    int unsigned gap;
    @(negedge clk);
    s_tdata  = {7'b0, tag, hour, day, act};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    n_sent++;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [TAG_W-1:0] rand_tag();
    return {$urandom, $urandom};
  endfunction

  // One random request; ins_pct sets the insert/delete mix.
  task automatic random_request(int unsigned ins_pct);
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    int unsigned      r;
    r = $urandom_range(99);
    if ($urandom_range(99) < ins_pct) begin
      // Mostly new keys; some reuse a held key to hit slot taken.
      if (r < 15 && board.pick_entry(key, tag)) begin
        send_request(ACT_INSERT, key[7:5], key[4:0], rand_tag());
      end else begin
        send_request(ACT_INSERT, 3'($urandom_range(7)),
                     5'(r < 75 ? $urandom_range(23) : $urandom_range(31)), rand_tag());
      end
    end else begin
      if (r < 70 && board.pick_entry(key, tag)) begin
        send_request(ACT_DELETE, key[7:5], key[4:0], tag);
      end else if (r < 85 && board.pick_entry(key, tag)) begin
        // right key, name off by one bit
        tag[$urandom_range(TAG_W - 1)] ^= 1'b1;
        send_request(ACT_DELETE, key[7:5], key[4:0], tag);
      end else begin
        send_request(ACT_DELETE, 3'($urandom_range(7)), 5'($urandom_range(31)), rand_tag());
      end
    end
  endtask

  task automatic run_phase(int unsigned ins_pct, int unsigned count);
    repeat (count) random_request(ins_pct);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: empty delete, key extremes, duplicate key, wrong
    // name, hours past 23, delete past the last entry.
    send_request(ACT_DELETE, 3'd3, 5'd12, 64'h0123_4567_89ab_cdef);
    send_request(ACT_INSERT, 3'd0, 5'd0,  64'h0);
    send_request(ACT_INSERT, 3'd7, 5'd31, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_INSERT, 3'd3, 5'd12, 64'h0123_4567_89ab_cdef);
    send_request(ACT_INSERT, 3'd3, 5'd12, 64'hfedc_ba98_7654_3210);
    send_request(ACT_DELETE, 3'd3, 5'd12, 64'hfedc_ba98_7654_3210);
    send_request(ACT_INSERT, 3'd3, 5'd24, 64'h5555_5555_5555_5555);
    send_request(ACT_INSERT, 3'd3, 5'd11, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(ACT_DELETE, 3'd7, 5'd30, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_DELETE, 3'd7, 5'd31, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_DELETE, 3'd7, 5'd31, 64'hffff_ffff_ffff_ffff);
    send_request(ACT_DELETE, 3'd0, 5'd0,  64'h1);
    send_request(ACT_DELETE, 3'd0, 5'd0,  64'h0);
    send_request(ACT_INSERT, 3'd0, 5'd31, 64'h8000_0000_0000_0001);
    send_request(ACT_DELETE, 3'd3, 5'd12, 64'h0123_4567_89ab_cdef);
    send_request(ACT_INSERT, 3'd7, 5'd0,  64'h7fff_ffff_ffff_fffe);
    send_request(ACT_INSERT, 3'd5, 5'd17, 64'h0f0f_0f0f_0f0f_0f0f);
    send_request(ACT_INSERT, 3'd5, 5'd16, 64'hf0f0_f0f0_f0f0_f0f0);
    send_request(ACT_INSERT, 3'd0, 5'd31, 64'h0);

    // Fill up to full under a long receiver hold-off, so the input stalls.
    hold_req = 1'b1;
    run_phase(88, 120);
    run_phase(20, 110);
    // Back to back, no idling, then a mixed phase and a draining phase.
    quiet = 1'b1;
    run_phase(90, 70);
    quiet = 1'b0;
    run_phase(55, 110);
    run_phase(10, 90);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);

    $display("%0d requests: %0d done, %0d slot taken, %0d not found, %0d table full",
             n_sent, board.seen[ST_DONE], board.seen[ST_TAKEN],
             board.seen[ST_MISSING], board.seen[ST_FULL]);
    $display("peak occupancy %0d of %0d, %0d cycles", board.peak_occ, TBL_DEPTH,
             cycle_count);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("** sorted_time_slot_table: PASSED **");
    end else begin
      $display("** sorted_time_slot_table: FAILED **");
    end
    $finish;
  end

endmodule
